// File: hdl/jtg_pkg.sv
// Shared types, constants and lookup tables for the Jalali to Gregorian date converter.
package jtg_pkg;

  // Field widths of the two channels.
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;

  // Width of the absolute day count after the epoch bias has been removed.
  localparam int unsigned DAYS_W = 21;

  // Jalali year offset and the combined epoch bias (355668 plus the month base of 31).
  localparam logic [12:0] JY_OFFSET  = 13'd1595;
  localparam logic [20:0] EPOCH_BIAS = 21'd355699;

  // Period lengths in days.
  localparam logic [20:0] DAYS_400Y = 21'd146097;
  localparam logic [17:0] DAYS_100Y = 18'd36524;
  localparam logic [15:0] DAYS_4Y   = 16'd1461;
  localparam logic [10:0] DAYS_1Y   = 11'd365;
  localparam logic [12:0] JCYCLE    = 13'd33;

  // Reciprocals floor(2^s / d); the estimate they give is low by at most one.
  localparam logic [7:0] RECIP_33   = 8'd248;  // s = 13
  localparam logic [4:0] RECIP_400Y = 5'd14;   // s = 21
  localparam logic [2:0] RECIP_100Y = 3'd7;    // s = 18
  localparam logic [5:0] RECIP_4Y   = 6'd44;   // s = 16
  localparam logic [2:0] RECIP_1Y   = 3'd5;    // s = 11

  // Day offset of each Jalali month code, plus 31 so that month zero stays non-negative.
  localparam logic [8:0] MONTH_OFS [16] = '{
    9'd0,   9'd31,  9'd62,  9'd93,  9'd124, 9'd155, 9'd186, 9'd217,
    9'd247, 9'd277, 9'd307, 9'd337, 9'd367, 9'd397, 9'd427, 9'd457
  };

  // Days in a common Gregorian year before month index m (m = 0 is the start of January).
  localparam logic [8:0] CUM_DAYS [16] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181, 9'd212,
    9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365, 9'd365
  };

  // Input transaction with its valid bit.
  typedef struct packed {
    logic               valid;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } jtg_jal_t;

  // Absolute day count leaving the front end.
  typedef struct packed {
    logic              valid;
    logic [DAYS_W-1:0] days;
  } jtg_days_t;

  // Result of the Gregorian period split.
  typedef struct packed {
    logic       valid;
    logic [3:0] n400;  // 400-year periods
    logic [1:0] n100;  // 100-year periods
    logic [4:0] n4;    // 4-year periods
    logic [1:0] n1;    // single years
    logic [8:0] doy;   // day of year, from zero
  } jtg_split_t;

  // Finished Gregorian date with its valid bit.
  typedef struct packed {
    logic               valid;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } jtg_greg_t;

  // Days before month index m, with the leap day counted from March onwards.
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    base = CUM_DAYS[m];
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// File: hdl/jtg_jal_if.sv
// Handshake interface carrying a Jalali date.
interface jtg_jal_if;
  import jtg_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  jalali_year;
  logic [MONTH_W-1:0] jalali_month;
  logic [DAY_W-1:0]   jalali_day;

  modport source (output valid, output jalali_year, output jalali_month,
                  output jalali_day, input ready);
  modport sink   (input valid, input jalali_year, input jalali_month,
                  input jalali_day, output ready);
endinterface

// File: hdl/jtg_greg_if.sv
// Handshake interface carrying a Gregorian date.
interface jtg_greg_if;
  import jtg_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  gregorian_year;
  logic [MONTH_W-1:0] gregorian_month;
  logic [DAY_W-1:0]   gregorian_day;

  modport source (output valid, output gregorian_year, output gregorian_month,
                  output gregorian_day, input ready);
  modport sink   (input valid, input gregorian_year, input gregorian_month,
                  input gregorian_day, output ready);
endinterface

// File: hdl/jtg_front.sv
// Three pipeline stages forming the absolute day count from a Jalali date.
module jtg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  jtg_pkg::jtg_jal_t jal_i,
  output jtg_pkg::jtg_days_t days_o
);
  import jtg_pkg::*;

  // Stage 1: shifted year, month offset and the estimate of year / 33.
  logic [12:0] s1_jy_d;
  logic [20:0] s1_prod;
  logic        s1_vld_q;
  logic [12:0] s1_jy_q;
  logic [7:0]  s1_q_q;
  logic [8:0]  s1_moff_q;
  logic [4:0]  s1_day_q;

  assign s1_jy_d = {1'b0, jal_i.year} + JY_OFFSET;
  assign s1_prod = {8'd0, s1_jy_d} * {13'd0, RECIP_33};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= jal_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_jy_q   <= s1_jy_d;
      s1_q_q    <= s1_prod[20:13];
      s1_moff_q <= MONTH_OFS[jal_i.month];
      s1_day_q  <= jal_i.day;
    end
  end

  // Stage 2: exact quotient and remainder of the 33-year cycle.
  logic [12:0] s2_mult;
  logic [12:0] s2_rem;
  logic        s2_corr;
  logic [7:0]  s2_q_d;
  logic [12:0] s2_r_full;
  logic        s2_vld_q;
  logic [12:0] s2_jy_q;
  logic [7:0]  s2_q_q;
  logic [5:0]  s2_r_q;
  logic [8:0]  s2_moff_q;
  logic [4:0]  s2_day_q;

  assign s2_mult   = {5'd0, s1_q_q} * JCYCLE;
  assign s2_rem    = s1_jy_q - s2_mult;
  assign s2_corr   = (s2_rem >= JCYCLE);
  assign s2_q_d    = s2_corr ? (s1_q_q + 8'd1) : s1_q_q;
  assign s2_r_full = s2_corr ? (s2_rem - JCYCLE) : s2_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_jy_q   <= s1_jy_q;
      s2_q_q    <= s2_q_d;
      s2_r_q    <= s2_r_full[5:0];
      s2_moff_q <= s1_moff_q;
      s2_day_q  <= s1_day_q;
    end
  end

  // Stage 3: sum of the year, leap, month and day terms less the epoch.
  // The true count is always positive and below 2^21, so modulo arithmetic is exact.
  logic [6:0]  s3_r3;
  logic [20:0] s3_days_d;
  logic        s3_vld_q;
  logic [20:0] s3_days_q;

  assign s3_r3     = {1'b0, s2_r_q} + 7'd3;
  assign s3_days_d = ({8'd0, s2_jy_q} * 21'd365)
                   + {10'd0, s2_q_q, 3'b000}
                   + {16'd0, s3_r3[6:2]}
                   + {16'd0, s2_day_q}
                   + {12'd0, s2_moff_q}
                   - EPOCH_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_days_q <= s3_days_d;
    end
  end

  assign days_o.valid = s3_vld_q;
  assign days_o.days  = s3_days_q;

endmodule

// File: hdl/jtg_split.sv
// Eight pipeline stages splitting the day count into Gregorian 400-, 100-, 4- and 1-year periods.
module jtg_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  jtg_pkg::jtg_days_t  days_i,
  output jtg_pkg::jtg_split_t split_o
);
  import jtg_pkg::*;

  // Stage 4: estimate of the 400-year period count.
  logic [24:0] s4_prod;
  logic        s4_vld_q;
  logic [20:0] s4_days_q;
  logic [3:0]  s4_qa_q;

  assign s4_prod = {4'd0, days_i.days} * {20'd0, RECIP_400Y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s4_vld_q <= days_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_days_q <= days_i.days;
      s4_qa_q   <= s4_prod[24:21];
    end
  end

  // Stage 5: exact 400-year count and remainder.
  logic [20:0] s5_mult;
  logic [20:0] s5_rem;
  logic        s5_corr;
  logic [20:0] s5_ra_full;
  logic        s5_vld_q;
  logic [3:0]  s5_a_q;
  logic [17:0] s5_ra_q;

  assign s5_mult    = {17'd0, s4_qa_q} * DAYS_400Y;
  assign s5_rem     = s4_days_q - s5_mult;
  assign s5_corr    = (s5_rem >= DAYS_400Y);
  assign s5_ra_full = s5_corr ? (s5_rem - DAYS_400Y) : s5_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en_i) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_a_q  <= s5_corr ? (s4_qa_q + 4'd1) : s4_qa_q;
      s5_ra_q <= s5_ra_full[17:0];
    end
  end

  // Stage 6: century test and estimate of the 100-year count on the shortened remainder.
  logic        s6_cen_d;
  logic [17:0] s6_x_d;
  logic [20:0] s6_prod;
  logic        s6_vld_q;
  logic [3:0]  s6_a_q;
  logic        s6_cen_q;
  logic [17:0] s6_ra_q;
  logic [17:0] s6_x_q;
  logic [1:0]  s6_qb_q;

  assign s6_cen_d = (s5_ra_q > DAYS_100Y);
  assign s6_x_d   = s5_ra_q - 18'd1;
  assign s6_prod  = {3'd0, s6_x_d} * {18'd0, RECIP_100Y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en_i) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_a_q   <= s5_a_q;
      s6_cen_q <= s6_cen_d;
      s6_ra_q  <= s5_ra_q;
      s6_x_q   <= s6_x_d;
      s6_qb_q  <= s6_prod[19:18];
    end
  end

  // Stage 7: exact 100-year count, leap-day restore, or the plain remainder without a century.
  logic [17:0] s7_mult;
  logic [17:0] s7_rem;
  logic        s7_corr;
  logic [17:0] s7_rb_full;
  logic [15:0] s7_rb;
  logic [15:0] s7_dc_d;
  logic [1:0]  s7_b_d;
  logic        s7_vld_q;
  logic [3:0]  s7_a_q;
  logic [1:0]  s7_b_q;
  logic [15:0] s7_dc_q;

  assign s7_mult    = {16'd0, s6_qb_q} * DAYS_100Y;
  assign s7_rem     = s6_x_q - s7_mult;
  assign s7_corr    = (s7_rem >= DAYS_100Y);
  assign s7_rb_full = s7_corr ? (s7_rem - DAYS_100Y) : s7_rem;
  assign s7_rb      = s7_rb_full[15:0];

  always_comb begin
    if (s6_cen_q) begin
      s7_b_d  = s7_corr ? (s6_qb_q + 2'd1) : s6_qb_q;
      s7_dc_d = s7_rb + {15'd0, (s7_rb >= {5'd0, DAYS_1Y})};
    end else begin
      s7_b_d  = 2'd0;
      s7_dc_d = s6_ra_q[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en_i) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_a_q  <= s6_a_q;
      s7_b_q  <= s7_b_d;
      s7_dc_q <= s7_dc_d;
    end
  end

  // Stage 8: estimate of the 4-year count.
  logic [20:0] s8_prod;
  logic        s8_vld_q;
  logic [3:0]  s8_a_q;
  logic [1:0]  s8_b_q;
  logic [15:0] s8_dc_q;
  logic [4:0]  s8_qc_q;

  assign s8_prod = {5'd0, s7_dc_q} * {15'd0, RECIP_4Y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en_i) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s8_a_q  <= s7_a_q;
      s8_b_q  <= s7_b_q;
      s8_dc_q <= s7_dc_q;
      s8_qc_q <= s8_prod[20:16];
    end
  end

  // Stage 9: exact 4-year count and remainder.
  logic [15:0] s9_mult;
  logic [15:0] s9_rem;
  logic        s9_corr;
  logic [15:0] s9_rc_full;
  logic        s9_vld_q;
  logic [3:0]  s9_a_q;
  logic [1:0]  s9_b_q;
  logic [4:0]  s9_c_q;
  logic [10:0] s9_rc_q;

  assign s9_mult    = {11'd0, s8_qc_q} * DAYS_4Y;
  assign s9_rem     = s8_dc_q - s9_mult;
  assign s9_corr    = (s9_rem >= DAYS_4Y);
  assign s9_rc_full = s9_corr ? (s9_rem - DAYS_4Y) : s9_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en_i) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s9_a_q  <= s8_a_q;
      s9_b_q  <= s8_b_q;
      s9_c_q  <= s9_corr ? (s8_qc_q + 5'd1) : s8_qc_q;
      s9_rc_q <= s9_rc_full[10:0];
    end
  end

  // Stage 10: test for a year past the first of the block and estimate the single-year count.
  logic        s10_yr_d;
  logic [10:0] s10_y_d;
  logic [12:0] s10_prod;
  logic        s10_vld_q;
  logic [3:0]  s10_a_q;
  logic [1:0]  s10_b_q;
  logic [4:0]  s10_c_q;
  logic        s10_yr_q;
  logic [10:0] s10_rc_q;
  logic [10:0] s10_y_q;
  logic [1:0]  s10_qd_q;

  assign s10_yr_d = (s9_rc_q > DAYS_1Y);
  assign s10_y_d  = s9_rc_q - 11'd1;
  assign s10_prod = {2'd0, s10_y_d} * {10'd0, RECIP_1Y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
    end else if (en_i) begin
      s10_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s10_a_q  <= s9_a_q;
      s10_b_q  <= s9_b_q;
      s10_c_q  <= s9_c_q;
      s10_yr_q <= s10_yr_d;
      s10_rc_q <= s9_rc_q;
      s10_y_q  <= s10_y_d;
      s10_qd_q <= s10_prod[12:11];
    end
  end

  // Stage 11: exact single-year count and the day of the year.
  logic [10:0] s11_mult;
  logic [10:0] s11_rem;
  logic        s11_corr;
  logic [10:0] s11_rd_full;
  logic [1:0]  s11_d_d;
  logic [8:0]  s11_doy_d;
  logic        s11_vld_q;
  logic [3:0]  s11_a_q;
  logic [1:0]  s11_b_q;
  logic [4:0]  s11_c_q;
  logic [1:0]  s11_d_q;
  logic [8:0]  s11_doy_q;

  assign s11_mult    = {9'd0, s10_qd_q} * DAYS_1Y;
  assign s11_rem     = s10_y_q - s11_mult;
  assign s11_corr    = (s11_rem >= DAYS_1Y);
  assign s11_rd_full = s11_corr ? (s11_rem - DAYS_1Y) : s11_rem;

  always_comb begin
    if (s10_yr_q) begin
      s11_d_d   = s11_corr ? (s10_qd_q + 2'd1) : s10_qd_q;
      s11_doy_d = s11_rd_full[8:0];
    end else begin
      s11_d_d   = 2'd0;
      s11_doy_d = s10_rc_q[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s11_vld_q <= 1'b0;
    end else if (en_i) begin
      s11_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s11_a_q   <= s10_a_q;
      s11_b_q   <= s10_b_q;
      s11_c_q   <= s10_c_q;
      s11_d_q   <= s11_d_d;
      s11_doy_q <= s11_doy_d;
    end
  end

  assign split_o.valid = s11_vld_q;
  assign split_o.n400  = s11_a_q;
  assign split_o.n100  = s11_b_q;
  assign split_o.n4    = s11_c_q;
  assign split_o.n1    = s11_d_q;
  assign split_o.doy   = s11_doy_q;

endmodule

// File: hdl/jtg_month.sv
// Two pipeline stages forming the Gregorian year and finding the month and day of month.
module jtg_month (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  jtg_pkg::jtg_split_t split_i,
  output jtg_pkg::jtg_greg_t  greg_o
);
  import jtg_pkg::*;

  // Stage 12: year from the period counts, leap flag and month from parallel compares.
  // The year is a multiple of 4 exactly when the single-year count is zero, of 100 when
  // the 4-year count is zero as well, and of 400 when the 100-year count is zero too.
  logic [12:0] s12_gy_d;
  logic        s12_leap_d;
  logic [8:0]  s12_gd_d;
  logic [11:0] s12_past;
  logic [3:0]  s12_mon_d;
  logic        s12_vld_q;
  logic [11:0] s12_gy_q;
  logic        s12_leap_q;
  logic [8:0]  s12_gd_q;
  logic [3:0]  s12_mon_q;

  assign s12_gy_d   = ({9'd0, split_i.n400} * 13'd400)
                    + ({11'd0, split_i.n100} * 13'd100)
                    + {6'd0, split_i.n4, 2'b00}
                    + {11'd0, split_i.n1};
  assign s12_leap_d = (split_i.n1 == 2'd0) &&
                      ((split_i.n4 != 5'd0) || (split_i.n100 == 2'd0));
  assign s12_gd_d   = split_i.doy + 9'd1;

  // One flag for each month the day has already run past.
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      s12_past[k] = (s12_gd_d > cum_days(4'(k + 1), s12_leap_d));
    end
  end

  assign s12_mon_d = 4'd1 + 4'($countones(s12_past));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_vld_q <= 1'b0;
    end else if (en_i) begin
      s12_vld_q <= split_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s12_gy_q   <= s12_gy_d[11:0];
      s12_leap_q <= s12_leap_d;
      s12_gd_q   <= s12_gd_d;
      s12_mon_q  <= s12_mon_d;
    end
  end

  // Stage 13: day of month, held in the output register.
  logic [8:0]  s13_day_d;
  logic        s13_vld_q;
  logic [11:0] s13_gy_q;
  logic [3:0]  s13_mon_q;
  logic [4:0]  s13_day_q;

  assign s13_day_d = s12_gd_q - cum_days(s12_mon_q - 4'd1, s12_leap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s13_vld_q <= 1'b0;
    end else if (en_i) begin
      s13_vld_q <= s12_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s13_gy_q  <= s12_gy_q;
      s13_mon_q <= s12_mon_q;
      s13_day_q <= s13_day_d[4:0];
    end
  end

  assign greg_o.valid = s13_vld_q;
  assign greg_o.year  = s13_gy_q;
  assign greg_o.month = s13_mon_q;
  assign greg_o.day   = s13_day_q;

endmodule

// File: hdl/jalali_to_gregorian_date_top.sv
// Top level of the Jalali to Gregorian date converter pipeline.
//
//   Port    Direction  Contents
//   jal_i   sink       jalali_year[11:0], jalali_month[3:0], jalali_day[4:0]
//   greg_o  source     gregorian_year[11:0], gregorian_month[3:0], gregorian_day[4:0]
//
// One transaction is taken every cycle while the output is not stalled; each result passes
// through the 13 register stages of the day count, period split and month search.
// Reset clears only the valid bits of the stages; no clearing pass is needed.
// When the result in the output register is not taken, the whole pipeline holds and
// jal_i.ready drops in the same cycle; nothing is lost or repeated.
module jalali_to_gregorian_date_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  jtg_jal_if.sink           jal_i,
  jtg_greg_if.source        greg_o
);
  import jtg_pkg::*;

  jtg_jal_t   jal_s;
  jtg_days_t  days_s;
  jtg_split_t split_s;
  jtg_greg_t  greg_s;
  logic       en;

  // The pipeline advances unless a finished result is waiting to be taken.
  assign en = !greg_s.valid || greg_o.ready;

  assign jal_i.ready = en;

  assign jal_s.valid = jal_i.valid;
  assign jal_s.year  = jal_i.jalali_year;
  assign jal_s.month = jal_i.jalali_month;
  assign jal_s.day   = jal_i.jalali_day;

  jtg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .jal_i  (jal_s),
    .days_o (days_s)
  );

  jtg_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .days_i  (days_s),
    .split_o (split_s)
  );

  jtg_month u_month (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .split_i (split_s),
    .greg_o  (greg_s)
  );

  // Output channel.
  assign greg_o.valid           = greg_s.valid;
  assign greg_o.gregorian_year  = greg_s.year;
  assign greg_o.gregorian_month = greg_s.month;
  assign greg_o.gregorian_day   = greg_s.day;

  // The period split never leaves a day beyond the length of its year.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    greg_o.valid |-> (greg_o.gregorian_month >= 4'd1) && (greg_o.gregorian_month <= 4'd12))
    else $error("Gregorian month out of range");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    greg_o.valid |-> (greg_o.gregorian_day != 5'd0))
    else $error("Gregorian day of zero");

  // A held result must stop the input side in the same cycle.
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (greg_o.valid && !greg_o.ready) |-> !jal_i.ready)
    else $error("Input taken while the output is stalled");

  // A taken result frees the pipeline for a new transaction.
  a_drain_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (greg_o.valid && greg_o.ready) |-> jal_i.ready)
    else $error("Input refused although the output moved");

endmodule
